/* rtl/tdpf_pkg.sv */
package tdpf_pkg;

   // Default sizes handed to the top level
   localparam int VALUE_BITS_DEF  = 32;
   localparam int TABLE_DEPTH_DEF = 8192;

   // Width of one base prime and of the base limit register
   localparam int PRIME_BITS = 17;

   // Register file
   localparam int CFG_ADDR_BITS = 4;
   localparam int CFG_DATA_BITS = 32;

   typedef enum logic [1:0] {
      REG_START_VALUE   = 2'd0,
      REG_PRIMES_WANTED = 2'd1,
      REG_BASE_LIMIT    = 2'd2,
      REG_UNUSED        = 2'd3
   } reg_index_type;

   localparam logic [31:0]           START_VALUE_RST   = 32'd0;
   localparam logic [31:0]           PRIMES_WANTED_RST = 32'd1;
   localparam logic [PRIME_BITS-1:0] BASE_LIMIT_RST    = 17'd65536;

   // Smallest odd candidate, lowest start of the search (the table build starts at FIRST_BUILD)
   localparam logic [31:0] MIN_CANDIDATE = 32'd3;
   localparam int          FIRST_BUILD   = 7;

   // Index of the last seed prime written at the start of a table build
   localparam logic [1:0] SEED_LAST = 2'd2;

   // Seed primes 2, 3 and 5
   function automatic logic [PRIME_BITS-1:0] seed_prime(input logic [1:0] k);
      logic [PRIME_BITS-1:0] v;
      unique case (k)
         2'd0:    v = 17'd2;
         2'd1:    v = 17'd3;
         default: v = 17'd5;
      endcase
      return v;
   endfunction

endpackage

/* rtl/trial_division_prime_finder.sv */
// Trial-division prime finder.
// Input channel (req_valid / req_stall, payload req_restart): one transfer asks
// for the next prime. With req_restart high the base prime table is rebuilt up
// to base_limit, the odd cursor is reloaded from start_value and the count is
// cleared before the search. A request gives at most one result on the rsp_
// channel: the prime, a last flag when the count reaches primes_wanted, and an
// unverified flag when the table runs out before the square root of the prime.
// A request after the last prime, or after cursor overflow, gives no result.
// One shared remainder unit does every trial division, one dividend bit per
// cycle, on a W = max(VALUE_BITS, 18) bit dividend; a candidate is divided by
// the table primes in order up to its square root or a divisor, and a request
// tests odd candidates until one passes or the cursor overflows.
// A restart first writes the seed primes 2, 3 and 5, then runs one table test
// for each number from 7 to base_limit (stopping early once the table is full).
// req_stall is high from the accepted request until its search ends and any
// result is in the output register; a finished result waits in the output
// register while rsp_stall is high, and the next request may be taken
// meanwhile. Reset clears the table count, cursor (to 3) and count and resets
// the configuration, not the table memory. Registers are at bytes 0, 4 and 8.
module trial_division_prime_finder
   import tdpf_pkg::*;
#(
   parameter int VALUE_BITS  = VALUE_BITS_DEF,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_restart,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [31:0]              rsp_prime_value,
   output logic                     rsp_last,
   output logic                     rsp_unverified,
   // register port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CFG_ADDR_BITS-1:0] paddr,
   input  logic [CFG_DATA_BITS-1:0] pwdata,
   output logic [CFG_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int TW   = (VALUE_BITS > 18) ? VALUE_BITS : 18;
   localparam int CMPW = (TW > 2 * PRIME_BITS) ? TW : 2 * PRIME_BITS;
   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int BW   = $clog2(TW);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SEED, ST_BUILD, ST_LOAD, ST_CHECK,
      ST_READ, ST_MUL, ST_CMP, ST_DIV, ST_EMIT
   } state_type;

   // configuration registers
   logic [31:0]           start_ff;
   logic [31:0]           wanted_ff;
   logic [PRIME_BITS-1:0] limit_ff;

   // control state
   state_type              state_ff, state_in;
   logic                   build_ff, build_in;
   logic [1:0]             seed_ff, seed_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [VALUE_BITS-1:0]  cursor_ff, cursor_in;
   logic                   over_ff, over_in;
   logic [31:0]            found_ff, found_in;
   logic [BW-1:0]          bit_ff, bit_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [TW-1:0]           dvd_ff, dvd_in;
   logic [PRIME_BITS-1:0]   rem_ff, rem_in;
   logic [2*PRIME_BITS-1:0] sq_ff, sq_in;
   logic                    exh_ff, exh_in;
   logic [31:0]             rsp_prime_ff, rsp_prime_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_unver_ff, rsp_unver_in;

   // table memory
   logic [PRIME_BITS-1:0] table_mem [TABLE_DEPTH];
   logic [PRIME_BITS-1:0] rd_ff;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [PRIME_BITS-1:0] mem_wdata;
   logic                  mem_re;

   // shared remainder step and test outcome
   logic [PRIME_BITS:0]     shifted;
   logic                    shift_ge;
   logic [PRIME_BITS-1:0]   rem_step;
   logic                    test_done;
   logic                    test_pass;
   logic                    test_exh;

   // start value adjustment
   logic [31:0]            start_odd;
   logic [31:0]            start_adj;
   logic [VALUE_BITS+31:0] start_wide;
   logic [VALUE_BITS+31:0] cand_wide;
   logic [31:0]            found_next;
   logic                   emit_go;
   logic                   req_xfer;
   logic                   cfg_write;
   reg_index_type          cfg_idx;

   assign req_xfer  = req_valid && !req_stall;
   assign cfg_write = psel && penable && pwrite && pready;
   assign cfg_idx   = reg_index_type'(paddr[3:2]);

   // register port
   assign pready = 1'b1;

   always_comb begin
      unique case (cfg_idx)
         REG_START_VALUE:   prdata = start_ff;
         REG_PRIMES_WANTED: prdata = wanted_ff;
         REG_BASE_LIMIT:    prdata = {{(CFG_DATA_BITS-PRIME_BITS){1'b0}}, limit_ff};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= START_VALUE_RST;
         wanted_ff <= PRIMES_WANTED_RST;
         limit_ff  <= BASE_LIMIT_RST;
      end else if (cfg_write) begin
         unique case (cfg_idx)
            REG_START_VALUE:   start_ff  <= pwdata;
            REG_PRIMES_WANTED: wanted_ff <= pwdata;
            REG_BASE_LIMIT:    limit_ff  <= pwdata[PRIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   // odd start at or below start_value, at least three
   assign start_odd  = (start_ff[0] || (start_ff == 32'd0)) ? start_ff : start_ff - 32'd1;
   assign start_adj  = (start_odd < MIN_CANDIDATE) ? MIN_CANDIDATE : start_odd;
   assign start_wide = {{VALUE_BITS{1'b0}}, start_adj};
   assign cand_wide  = {32'd0, dvd_ff[VALUE_BITS-1:0]};
   assign found_next = found_ff + 32'd1;
   assign emit_go    = !rsp_valid_ff || !rsp_stall;

   // one restoring remainder step
   assign shifted  = {rem_ff, dvd_ff[bit_ff]};
   assign shift_ge = shifted >= {1'b0, rd_ff};
   assign rem_step = shift_ge ? PRIME_BITS'(shifted - {1'b0, rd_ff})
                              : PRIME_BITS'(shifted);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      build_in     = build_ff;
      seed_in      = seed_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      cursor_in    = cursor_ff;
      over_in      = over_ff;
      found_in     = found_ff;
      bit_in       = bit_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      sq_in        = sq_ff;
      exh_in       = exh_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_prime_in = rsp_prime_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_unver_in = rsp_unver_ff;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[AW-1:0];
      mem_wdata    = dvd_ff[PRIME_BITS-1:0];
      mem_re       = 1'b0;
      test_done    = 1'b0;
      test_pass    = 1'b0;
      test_exh     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_restart) begin
                  count_in = '0;
                  seed_in  = '0;
                  state_in = ST_SEED;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_SEED: begin
            mem_we    = 1'b1;
            mem_wdata = seed_prime(seed_ff);
            count_in  = count_ff + CW'(1);
            seed_in   = seed_ff + 2'd1;
            if (seed_ff == SEED_LAST) begin
               dvd_in   = TW'(FIRST_BUILD);
               state_in = ST_BUILD;
            end
         end
         ST_BUILD: begin
            // a full table cannot change any more
            if ((dvd_ff > TW'(limit_ff)) || (count_ff == CW'(TABLE_DEPTH))) begin
               state_in = ST_LOAD;
            end else begin
               build_in = 1'b1;
               idx_in   = '0;
               state_in = ST_READ;
            end
         end
         ST_LOAD: begin
            cursor_in = start_wide[VALUE_BITS-1:0];
            over_in   = |start_wide[VALUE_BITS+31:VALUE_BITS];
            found_in  = '0;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if ((found_ff >= wanted_ff) || over_ff) begin
               state_in = ST_IDLE;
            end else begin
               build_in = 1'b0;
               dvd_in   = TW'(cursor_ff);
               idx_in   = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (idx_ff == count_ff) begin
               test_done = 1'b1;
               test_pass = 1'b1;
               test_exh  = 1'b1;
            end else begin
               mem_re   = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            sq_in    = rd_ff * rd_ff;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (CMPW'(sq_ff) > CMPW'(dvd_ff)) begin
               test_done = 1'b1;
               test_pass = 1'b1;
            end else begin
               rem_in   = '0;
               bit_in   = BW'(TW - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = rem_step;
            bit_in = bit_ff - BW'(1);
            if (bit_ff == '0) begin
               if (rem_step == '0) begin
                  test_done = 1'b1;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = ST_READ;
               end
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = cand_wide[31:0];
               rsp_last_in  = (found_next == wanted_ff);
               rsp_unver_in = exh_ff;
               found_in     = found_next;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // end of one table test
      if (test_done) begin
         if (build_ff) begin
            if (test_pass && (count_ff < CW'(TABLE_DEPTH))) begin
               mem_we   = 1'b1;
               count_in = count_ff + CW'(1);
            end
            dvd_in   = dvd_ff + TW'(1);
            state_in = ST_BUILD;
         end else begin
            if (&dvd_ff[VALUE_BITS-1:1]) begin
               over_in = 1'b1;
            end else begin
               cursor_in = dvd_ff[VALUE_BITS-1:0] + VALUE_BITS'(2);
            end
            if (test_pass) begin
               exh_in   = test_exh;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_CHECK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         build_ff     <= 1'b0;
         seed_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         cursor_ff    <= VALUE_BITS'(MIN_CANDIDATE);
         over_ff      <= 1'b0;
         found_ff     <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         build_ff     <= build_in;
         seed_ff      <= seed_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         cursor_ff    <= cursor_in;
         over_ff      <= over_in;
         found_ff     <= found_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      sq_ff        <= sq_in;
      exh_ff       <= exh_in;
      rsp_prime_ff <= rsp_prime_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_unver_ff <= rsp_unver_in;
   end

   // base prime table, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= table_mem[idx_ff[AW-1:0]];
      end
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_value = rsp_prime_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_unverified  = rsp_unver_ff;

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("table count beyond table depth");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < rd_ff))
      else $error("partial remainder not below divisor");

   a_found_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && emit_go) |=> (found_ff == $past(found_ff) + 32'd1))
      else $error("found count did not advance on emission");

   a_prime_odd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_prime_ff[0])
      else $error("even value presented as prime");

endmodule

/* dv/tb_trial_division_prime_finder.sv */
module tb_trial_division_prime_finder
   import tdpf_pkg::*;
();

   localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS_DEF) - 64'd1;
   localparam int QUIET_LIMIT     = 1_000_000;
   localparam int HOLD_CYCLES     = 5000;
   localparam int SETTLE_CYCLES   = 20;
   localparam int ITEMS_PER_PHASE = 35;
   localparam int PROBE_COUNT     = 25;

   typedef struct packed {
      logic [31:0] prime;
      logic        last;
      logic        unverified;
   } prime_result_type;

   // how a directed row is checked
   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_GIVEN,
      CHK_SILENT
   } check_mode_type;

   typedef struct packed {
      logic                  reconfig;
      logic [31:0]           start;
      logic [31:0]           wanted;
      logic [PRIME_BITS-1:0] limit;
      logic                  restart;
      check_mode_type        chk;
      prime_result_type      given;
   } probe_row_type;

   // directed stimulus: register settings (written first where reconfig is set),
   // restart bit, and how the result is checked
   localparam probe_row_type PROBE_ROWS [PROBE_COUNT] = '{
      // no restart since reset: empty table, every odd number passes
      '{1'b0, 32'd0, 32'd1, 17'd0, 1'b0, CHK_GIVEN, '{32'd3, 1'b1, 1'b1}},
      '{1'b0, 32'd0, 32'd1, 17'd0, 1'b0, CHK_SILENT, '0},
      // new start value and base limit are held back until a restart; primes_wanted applies at once
      '{1'b1, 32'd100, 32'd3, 17'd7, 1'b0, CHK_GIVEN, '{32'd5, 1'b0, 1'b1}},
      '{1'b0, 32'd0, 32'd0, 17'd0, 1'b0, CHK_GIVEN, '{32'd7, 1'b1, 1'b1}},
      '{1'b0, 32'd0, 32'd0, 17'd0, 1'b0, CHK_SILENT, '0},
      '{1'b0, 32'd0, 32'd0, 17'd0, 1'b1, CHK_MODEL, '0},
      '{1'b0, 32'd0, 32'd0, 17'd0, 1'b0, CHK_MODEL, '0},
      '{1'b0, 32'd0, 32'd0, 17'd0, 1'b0, CHK_MODEL, '0},
      // top of range and divisible: cursor runs out during the search
      '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd6, 1'b1, CHK_SILENT, '0},
      // largest 32-bit prime, table of seeds only
      '{1'b1, 32'hFFFF_FFFB, 32'd2, 17'd0, 1'b1, CHK_GIVEN, '{32'hFFFF_FFFB, 1'b0, 1'b1}},
      '{1'b0, 32'd0, 32'd0, 17'd0, 1'b0, CHK_MODEL, '0},
      '{1'b0, 32'd0, 32'd0, 17'd0, 1'b0, CHK_SILENT, '0},
      // more primes wanted, but the cursor overflows during the search
      '{1'b1, 32'hFFFF_FFFB, 32'd5, 17'd0, 1'b0, CHK_SILENT, '0},
      '{1'b0, 32'd0, 32'd0, 17'd0, 1'b0, CHK_SILENT, '0},
      // zero primes wanted
      '{1'b1, 32'd0, 32'd0, 17'd7, 1'b1, CHK_SILENT, '0},
      // start below three, small table
      '{1'b1, 32'd1, 32'd4, 17'd30, 1'b1, CHK_GIVEN, '{32'd3, 1'b0, 1'b0}},
      '{1'b0, 32'd0, 32'd0, 17'd0, 1'b0, CHK_MODEL, '0},
      '{1'b0, 32'd0, 32'd0, 17'd0, 1'b0, CHK_MODEL, '0},
      '{1'b0, 32'd0, 32'd0, 17'd0, 1'b0, CHK_MODEL, '0},
      // even start values
      '{1'b1, 32'd2, 32'd2, 17'd100, 1'b1, CHK_MODEL, '0},
      '{1'b1, 32'hFFFF_FFFE, 32'd1, 17'd7, 1'b1, CHK_MODEL, '0},
      // larger table, search near 2^31
      '{1'b1, 32'h7FFF_FFFF, 32'd2, 17'd1000, 1'b1, CHK_MODEL, '0},
      '{1'b0, 32'd0, 32'd0, 17'd0, 1'b0, CHK_MODEL, '0},
      // top base limits written but left unused: search carries on
      '{1'b1, 32'd0, 32'hFFFF_FFFF, 17'h1FFFF, 1'b0, CHK_MODEL, '0},
      '{1'b1, 32'd0, 32'hFFFF_FFFF, 17'd65536, 1'b0, CHK_MODEL, '0}
   };

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_restart;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [31:0]              rsp_prime_value;
   logic                     rsp_last;
   logic                     rsp_unverified;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CFG_ADDR_BITS-1:0] paddr;
   logic [CFG_DATA_BITS-1:0] pwdata;
   logic [CFG_DATA_BITS-1:0] prdata;
   logic                     pready;

   // predictor state
   logic [PRIME_BITS-1:0] base_table [TABLE_DEPTH_DEF];
   int unsigned           table_len    = 0;
   longint unsigned       cursor       = 3;
   bit                    cursor_spent = 1'b0;
   logic [31:0]           primes_found = '0;
   logic [31:0]           cfg_start    = START_VALUE_RST;
   logic [31:0]           cfg_wanted   = PRIMES_WANTED_RST;
   logic [PRIME_BITS-1:0] cfg_limit    = BASE_LIMIT_RST;

   prime_result_type primes_due [$];
   int            mismatches    = 0;
   int            items_counted = 0;
   int            send_idle_pct = 0;
   int            rsp_idle_pct  = 0;
   int            quiet_cycles  = 0;
   bit            hold_armed    = 1'b0;
   bit            hold_done     = 1'b0;

   trial_division_prime_finder #(
      .VALUE_BITS  (VALUE_BITS_DEF),
      .TABLE_DEPTH (TABLE_DEPTH_DEF)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_prime_value (rsp_prime_value),
      .rsp_last        (rsp_last),
      .rsp_unverified  (rsp_unverified),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #1 clock = ~clock;

   function automatic void note_mismatch(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch %0d: %s expected %0h got %0h", mismatches, what, want, got);
      end
   endfunction

   // ---------------- predictor ----------------

   // no table prime p with p*p <= n divides n
   function automatic bit clears_table(input longint unsigned n);
      longint unsigned p;
      for (int unsigned i = 0; i < table_len; i++) begin
         p = 64'(base_table[i]);
         if (p * p > n) break;
         if (p != 0 && n % p == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void table_push(input logic [PRIME_BITS-1:0] v);
      if (table_len < TABLE_DEPTH_DEF) begin
         base_table[table_len] = v;
         table_len++;
      end
   endfunction

   // rebuild the base primes, reload the cursor and clear the count
   function automatic void rebuild_search();
      longint unsigned s;
      table_len = 0;
      table_push(17'd2);
      table_push(17'd3);
      table_push(17'd5);
      for (int unsigned n = FIRST_BUILD; n <= cfg_limit; n++) begin
         if (clears_table(n)) table_push(n[PRIME_BITS-1:0]);
      end
      s = 64'(cfg_start);
      if (s[0] == 1'b0 && s != 0) s = s - 1;
      if (s < MIN_CANDIDATE) s = 64'(MIN_CANDIDATE);
      cursor       = s;
      cursor_spent = (s > VALUE_MAX);
      primes_found = '0;
   endfunction

   // next prime for one request; returns 0 where the request gives nothing
   function automatic bit next_prime(input logic restart, output prime_result_type res);
      longint unsigned cand;
      longint unsigned top;
      bit              found;
      res   = '0;
      cand  = 0;
      found = 1'b0;
      if (restart) rebuild_search();
      if (primes_found >= cfg_wanted) return 1'b0;
      while (!cursor_spent && !found) begin
         cand  = cursor;
         found = clears_table(cand);
         if (cand > VALUE_MAX - 2) cursor_spent = 1'b1;
         else cursor = cand + 2;
      end
      if (!found) return 1'b0;
      primes_found = primes_found + 32'd1;
      if (table_len > 0) top = 64'(base_table[table_len-1]);
      else top = 0;
      res.prime      = cand[31:0];
      res.last       = (primes_found == cfg_wanted);
      res.unverified = (cand > top * top);
      return 1'b1;
   endfunction

   function automatic void cfg_store(input reg_index_type idx, input logic [31:0] val);
      case (idx)
         REG_START_VALUE:   cfg_start  = val;
         REG_PRIMES_WANTED: cfg_wanted = val;
         REG_BASE_LIMIT:    cfg_limit  = val[PRIME_BITS-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic [31:0] cfg_value(input reg_index_type idx);
      case (idx)
         REG_START_VALUE:   return cfg_start;
         REG_PRIMES_WANTED: return cfg_wanted;
         REG_BASE_LIMIT:    return {{(32-PRIME_BITS){1'b0}}, cfg_limit};
         default:           return '0;
      endcase
   endfunction

   // ---------------- drivers ----------------
   // All tasks start and end at a falling edge with nothing yet driven there.

   // optional write, then read back and compare
   task automatic csr_access(input bit do_write, input reg_index_type idx,
                             input logic [31:0] val);
      logic [31:0] seen;
      if (do_write) begin
         psel    <= 1'b1;
         penable <= 1'b0;
         pwrite  <= 1'b1;
         paddr   <= {idx, 2'b00};
         pwdata  <= val;
         @(negedge clock);
         penable <= 1'b1;
         @(posedge clock);
         while (!pready) @(posedge clock);
         cfg_store(idx, val);
         @(negedge clock);
      end
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      seen = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (seen !== cfg_value(idx)) note_mismatch("register readback", cfg_value(idx), seen);
      @(negedge clock);
   endtask

   // one request transfer, with random idle cycles ahead of it
   task automatic send_item(input logic restart, input check_mode_type chk,
                            input prime_result_type given);
      prime_result_type due;
      bit               hit;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      hit = next_prime(restart, due);
      if (chk == CHK_GIVEN) primes_due.push_back(given);
      else if (chk == CHK_MODEL && hit) primes_due.push_back(due);
      items_counted++;
      @(negedge clock);
   endtask

   // wait until every prime has arrived and the search has ended
   task automatic drain();
      req_valid <= 1'b0;
      repeat (2) @(negedge clock);
      while (primes_due.size() != 0 || req_stall) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic reconfigure(input logic [31:0] s, input logic [31:0] w,
                              input logic [PRIME_BITS-1:0] lim);
      drain();
      csr_access(1'b1, REG_START_VALUE, s);
      csr_access(1'b1, REG_PRIMES_WANTED, w);
      csr_access(1'b1, REG_BASE_LIMIT, {{(32-PRIME_BITS){1'b0}}, lim});
   endtask

   // random settings, then mostly a restart followed by plain requests
   task automatic run_segment(input bit fresh, input bit squeeze);
      logic [31:0]           s;
      logic [31:0]           w;
      logic [PRIME_BITS-1:0] lim;
      int                    len;
      bit                    lead;
      case ($urandom_range(3))
         0:       s = $urandom_range(2000);
         1:       s = $urandom;
         2:       s = 32'hFFFF_FFFF - $urandom_range(300);
         default: s = $urandom_range(1 << 20);
      endcase
      case ($urandom_range(19))
         0:       w = '0;
         1:       w = 32'hFFFF_FFFF;
         2:       w = $urandom;
         default: w = $urandom_range(8, 1);
      endcase
      if ($urandom_range(4) == 0) lim = PRIME_BITS'($urandom_range(300, 121));
      else lim = PRIME_BITS'($urandom_range(120));
      len  = $urandom_range(12, 4);
      lead = fresh || ($urandom_range(9) != 0);
      // filling the block: small table, unlimited count, long run
      if (squeeze) begin
         s    = $urandom_range(2000);
         w    = 32'hFFFF_FFFF;
         lim  = PRIME_BITS'($urandom_range(40, 7));
         len  = 12;
         lead = 1'b1;
      end
      reconfigure(s, w, lim);
      if (squeeze) hold_armed = 1'b1;
      for (int k = 0; k < len; k++) begin
         send_item((k == 0) ? lead : ($urandom_range(19) == 0), CHK_MODEL, '0);
      end
   endtask

   // receiver: random stalls, plus one long hold-off when armed
   initial begin : rsp_side
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // result check against the oldest pending prime
   always @(posedge clock) begin : rsp_check
      prime_result_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (primes_due.size() == 0) begin
            note_mismatch("result with none pending", '0, rsp_prime_value);
         end else begin
            due = primes_due.pop_front();
            if (rsp_prime_value !== due.prime)
               note_mismatch("prime_value", due.prime, rsp_prime_value);
            if (rsp_last !== due.last)
               note_mismatch("last", {31'd0, due.last}, {31'd0, rsp_last});
            if (rsp_unverified !== due.unverified)
               note_mismatch("unverified", {31'd0, due.unverified}, {31'd0, rsp_unverified});
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int goal;
      bit fresh;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_restart   = 1'b0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      send_idle_pct = 34;
      rsp_idle_pct  = 79;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register values after reset
      csr_access(1'b0, REG_START_VALUE, '0);
      csr_access(1'b0, REG_PRIMES_WANTED, '0);
      csr_access(1'b0, REG_BASE_LIMIT, '0);

      // directed rows
      for (int i = 0; i < PROBE_COUNT; i++) begin
         if (PROBE_ROWS[i].reconfig) begin
            reconfigure(PROBE_ROWS[i].start, PROBE_ROWS[i].wanted, PROBE_ROWS[i].limit);
         end
         send_item(PROBE_ROWS[i].restart, PROBE_ROWS[i].chk, PROBE_ROWS[i].given);
      end

      // random phases: sender mostly busy, then receiver mostly busy, then no idling
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 79;
            rsp_idle_pct  = 34;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         goal  = items_counted + ITEMS_PER_PHASE;
         fresh = 1'b1;
         while (items_counted < goal) begin
            run_segment(fresh, phase == 2 && fresh);
            fresh = 1'b0;
         end
      end

      drain();
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
